// ===== sv/tcct_pkg.sv =====
// Shared types, widths and codes for the text console cursor tracker.
`timescale 1ns / 1ps
`default_nettype none
package tcct_pkg;

	// field and register widths
	localparam int COORD_BITS = 16;
	localparam int DIM_BITS   = 13;
	localparam int CNT_BITS   = 16;
	localparam int MODE_BITS  = 4;
	localparam int ATTR_BITS  = 16;
	localparam int WIDE_BITS  = COORD_BITS + 2;

	// iterative divider: one quotient bit per cycle
	localparam int DIV_STEPS = CNT_BITS;
	localparam int STEP_BITS = $clog2(DIV_STEPS);

	// buffer dimension limits
	localparam logic [DIM_BITS-1:0] DIM_MIN = DIM_BITS'(1);
	localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(4096);

	// register reset values
	localparam logic [DIM_BITS-1:0]  WIDTH_RST = DIM_BITS'(80);
	localparam logic [DIM_BITS-1:0]  COUNT_RST = DIM_BITS'(25);
	localparam logic [ATTR_BITS-1:0] ATTR_RST  = ATTR_BITS'(7);

	// configuration port
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;
	localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] REG_LINE_COUNT = 2'd1;
	localparam logic [1:0] REG_FILL_ATTR  = 2'd2;

	// command codes
	localparam logic [MODE_BITS-1:0] MODE_CR       = 4'd0;
	localparam logic [MODE_BITS-1:0] MODE_LF       = 4'd1;
	localparam logic [MODE_BITS-1:0] MODE_ADVANCE  = 4'd2;
	localparam logic [MODE_BITS-1:0] MODE_BACK     = 4'd3;
	localparam logic [MODE_BITS-1:0] MODE_LEFT     = 4'd4;
	localparam logic [MODE_BITS-1:0] MODE_RIGHT    = 4'd5;
	localparam logic [MODE_BITS-1:0] MODE_FROM_ORG = 4'd6;
	localparam logic [MODE_BITS-1:0] MODE_TO_ORG   = 4'd7;
	localparam logic [MODE_BITS-1:0] MODE_SET      = 4'd8;
	localparam logic [MODE_BITS-1:0] MODE_INIT     = 4'd9;
	localparam logic [MODE_BITS-1:0] MODE_SYNC     = 4'd10;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the input beat, start the divider
		logic step;   // one divider iteration
		logic exec;   // apply the command, load the output register
	} dp_cmd_t;

endpackage
`default_nettype wire

// ===== sv/tcct_ctrl.sv =====
// Command sequencer: input/output handshake, divider step count, output valid.
`timescale 1ns / 1ps
`default_nettype none
module tcct_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	output tcct_pkg::dp_cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	localparam logic [tcct_pkg::STEP_BITS-1:0] LAST_STEP =
		tcct_pkg::STEP_BITS'(tcct_pkg::DIV_STEPS - 1);

	logic [1:0]                    state_q;
	logic [tcct_pkg::STEP_BITS-1:0] step_q;
	logic                          out_valid_q;
	logic                          out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// commands
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.step = (state_q == ST_DIV);
		cmd.exec = (state_q == ST_EXEC) && out_free;
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + tcct_pkg::STEP_BITS'(1);
					if (step_q == LAST_STEP) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output beat valid: set on exec, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV && step_q == '0))
		else $error("accepted beat did not start the divider");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == LAST_STEP) |=> (state_q == ST_EXEC))
		else $error("divider did not finish after its last step");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && !$past(cmd.exec)))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== sv/tcct_dp.sv =====
// Datapath: command capture, count/width divider, cursor and origin state, result register.
`timescale 1ns / 1ps
`default_nettype none
module tcct_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  tcct_pkg::dp_cmd_t                   cmd,
	input  wire  [tcct_pkg::MODE_BITS-1:0]      mode,
	input  wire  [tcct_pkg::CNT_BITS-1:0]       count,
	input  wire  [tcct_pkg::COORD_BITS-1:0]     new_x,
	input  wire  [tcct_pkg::COORD_BITS-1:0]     new_y,
	input  wire  [tcct_pkg::DIM_BITS-1:0]       line_width,
	input  wire  [tcct_pkg::DIM_BITS-1:0]       line_count,
	output logic [tcct_pkg::COORD_BITS-1:0]     cursor_x,
	output logic [tcct_pkg::COORD_BITS-1:0]     cursor_y,
	output logic                                cursor_moved,
	output logic                                scroll_up,
	output logic                                out_of_range,
	output logic [tcct_pkg::COORD_BITS-1:0]     origin_y
);

	localparam tcct_pkg::coord_t C_ONE = tcct_pkg::coord_t'(1);
	localparam tcct_pkg::wide_t  W_ONE = tcct_pkg::wide_t'(1);

	// captured command
	logic [tcct_pkg::MODE_BITS-1:0] mode_q;
	tcct_pkg::coord_t               nx_q, ny_q;
	logic                           cnt_zero_q;

	// divider
	logic [tcct_pkg::CNT_BITS-1:0]  quo_q;
	logic [tcct_pkg::DIM_BITS-1:0]  rem_q;
	logic [tcct_pkg::DIM_BITS-1:0]  rem_sh;
	logic                           rem_ge;

	// cursor and origin
	tcct_pkg::coord_t cur_x_q, cur_y_q, org_x_q, org_y_q;

	// next values
	tcct_pkg::coord_t nx, ny, nox, noy;
	logic             mv, sc, oor;

	logic [tcct_pkg::DIM_BITS-1:0] w, h;
	tcct_pkg::wide_t  we, he, xe, ye, re;
	tcct_pkg::coord_t quo_c, y_minus_q, base_x, base_y, sum_x, row_q;
	logic             sum_wrap;

	// clamp dimensions to 1..4096
	always_comb begin
		if (line_width == '0)                 w = tcct_pkg::DIM_MIN;
		else if (line_width > tcct_pkg::DIM_MAX) w = tcct_pkg::DIM_MAX;
		else                                  w = line_width;
		if (line_count == '0)                 h = tcct_pkg::DIM_MIN;
		else if (line_count > tcct_pkg::DIM_MAX) h = tcct_pkg::DIM_MAX;
		else                                  h = line_count;
	end

	// restoring division step, remainder stays below w
	assign rem_sh = {rem_q[tcct_pkg::DIM_BITS-2:0], quo_q[tcct_pkg::CNT_BITS-1]};
	assign rem_ge = (rem_sh >= w);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= mode;
			nx_q       <= tcct_pkg::coord_t'(new_x);
			ny_q       <= tcct_pkg::coord_t'(new_y);
			cnt_zero_q <= (count == '0);
			quo_q      <= count;
			rem_q      <= '0;
		end else if (cmd.step) begin
			rem_q <= rem_ge ? (rem_sh - w) : rem_sh;
			quo_q <= {quo_q[tcct_pkg::CNT_BITS-2:0], rem_ge};
		end
	end

	// shared terms
	assign we    = tcct_pkg::wide_t'(w);
	assign he    = tcct_pkg::wide_t'(h);
	assign xe    = tcct_pkg::wide_t'(cur_x_q);
	assign ye    = tcct_pkg::wide_t'(cur_y_q);
	assign re    = tcct_pkg::wide_t'(rem_q);
	assign quo_c = tcct_pkg::coord_t'(quo_q);
	assign y_minus_q = cur_y_q - quo_c;
	assign base_x = (mode_q == tcct_pkg::MODE_FROM_ORG) ? org_x_q : cur_x_q;
	assign base_y = (mode_q == tcct_pkg::MODE_FROM_ORG) ? org_y_q : cur_y_q;
	assign sum_x  = tcct_pkg::coord_t'(tcct_pkg::wide_t'(base_x) + re);
	assign row_q  = base_y + quo_c;
	assign sum_wrap = (tcct_pkg::wide_t'(sum_x) >= we);

	// command decode
	always_comb begin
		nx  = cur_x_q;
		ny  = cur_y_q;
		nox = org_x_q;
		noy = org_y_q;
		mv  = 1'b0;
		sc  = 1'b0;
		case (mode_q)
			tcct_pkg::MODE_CR: begin
				nx = '0;
				mv = 1'b1;
			end
			tcct_pkg::MODE_LF: begin
				if (ye + W_ONE == he) begin
					sc  = 1'b1;
					noy = org_y_q - C_ONE;
				end else begin
					ny = cur_y_q + C_ONE;
					mv = 1'b1;
				end
			end
			tcct_pkg::MODE_ADVANCE: begin
				if (xe + W_ONE >= we) begin
					nx = '0;
					if (ye + W_ONE == he) begin
						sc  = 1'b1;
						noy = org_y_q - C_ONE;
					end else begin
						ny = cur_y_q + C_ONE;
					end
				end else begin
					nx = cur_x_q + C_ONE;
				end
				mv = 1'b1;
			end
			tcct_pkg::MODE_BACK: begin
				if (cur_x_q != '0) begin
					nx = cur_x_q - C_ONE;
				end else begin
					ny = cur_y_q - C_ONE;
					nx = tcct_pkg::coord_t'(we - W_ONE);
				end
				mv = 1'b1;
			end
			tcct_pkg::MODE_LEFT: begin
				if (!cnt_zero_q) begin
					// borrow one row when the remainder passes the column
					if (re > xe) begin
						ny = y_minus_q - C_ONE;
						nx = tcct_pkg::coord_t'(we - re + xe);
					end else begin
						ny = y_minus_q;
						nx = tcct_pkg::coord_t'(xe - re);
					end
					mv = 1'b1;
				end
			end
			tcct_pkg::MODE_RIGHT, tcct_pkg::MODE_FROM_ORG: begin
				if (!cnt_zero_q || mode_q == tcct_pkg::MODE_FROM_ORG) begin
					if (sum_wrap) begin
						nx = tcct_pkg::coord_t'(tcct_pkg::wide_t'(sum_x) - we);
						ny = row_q + C_ONE;
					end else begin
						nx = sum_x;
						ny = row_q;
					end
					mv = 1'b1;
				end
			end
			tcct_pkg::MODE_TO_ORG: begin
				nx = org_x_q;
				ny = org_y_q;
				mv = 1'b1;
			end
			tcct_pkg::MODE_SET: begin
				nx = nx_q;
				ny = ny_q;
				mv = 1'b1;
			end
			tcct_pkg::MODE_INIT: begin
				nx  = nx_q;
				ny  = ny_q;
				nox = nx_q;
				noy = ny_q;
				mv  = 1'b1;
			end
			tcct_pkg::MODE_SYNC: begin
				mv = 1'b1;
			end
			default: begin
				mv = 1'b0;
			end
		endcase
		oor = mv && (nx[tcct_pkg::COORD_BITS-1] || tcct_pkg::wide_t'(nx) >= we ||
		             ny[tcct_pkg::COORD_BITS-1] || tcct_pkg::wide_t'(ny) >= he);
	end

	// cursor and origin state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
		end else if (cmd.exec) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			org_x_q <= nox;
			org_y_q <= noy;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			cursor_x     <= nx;
			cursor_y     <= ny;
			cursor_moved <= mv;
			scroll_up    <= sc;
			out_of_range <= oor;
			origin_y     <= noy;
		end
	end

endmodule
`default_nettype wire

// ===== sv/text_console_cursor_tracker_top.sv =====
// Top level: stream ports, configuration registers, sequencer and datapath.
//
// Usage: one command beat enters on the s_ channel (s_tuser = mode, s_tdata =
// count, new_x, new_y) and exactly one result beat leaves on the m_ channel.
// The register port sets line width, line count and the scroll fill attribute;
// write it only while no command is in flight.
// Sequence: an accepted command runs through the bit-serial count/width divider
// after the capture, then the apply step loads the output register and raises
// m_tvalid. A new command is accepted only once the previous one is applied;
// the capture, the divider steps and the apply step of two commands never overlap.
// s_tready is high only while the sequencer is idle. A result not yet taken
// waits in the output register while the next command is accepted and divided;
// that command then holds before its apply cycle until m_tready frees the
// register, so nothing is lost or repeated when the receiver stalls.
// Reset (arst_n low) clears cursor and origin to zero, empties the output and
// restores width 80, count 25 and fill attribute 7.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_tracker_top (
	input  wire         clk,
	input  wire         arst_n,
	// command stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // count[15:0], new_x[31:16], new_y[47:32]
	input  wire  [3:0]  s_tuser,   // mode[3:0]
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // cursor_x[15:0], cursor_y[31:16], cursor_moved[32],
	                               // scroll_up[33], out_of_range[34], origin_y[50:35], zero
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [tcct_pkg::DIM_BITS-1:0]  line_width_q;
	logic [tcct_pkg::DIM_BITS-1:0]  line_count_q;
	logic [tcct_pkg::ATTR_BITS-1:0] fill_attr_q;
	logic                           cfg_wr;
	logic [1:0]                     reg_idx;

	tcct_pkg::dp_cmd_t              cmd;
	logic [tcct_pkg::COORD_BITS-1:0] cursor_x, cursor_y, origin_y;
	logic                           cursor_moved, scroll_up, out_of_range;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= tcct_pkg::WIDTH_RST;
			line_count_q <= tcct_pkg::COUNT_RST;
			fill_attr_q  <= tcct_pkg::ATTR_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				tcct_pkg::REG_LINE_WIDTH: line_width_q <= pwdata[tcct_pkg::DIM_BITS-1:0];
				tcct_pkg::REG_LINE_COUNT: line_count_q <= pwdata[tcct_pkg::DIM_BITS-1:0];
				tcct_pkg::REG_FILL_ATTR:  fill_attr_q  <= pwdata[tcct_pkg::ATTR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tcct_pkg::REG_LINE_WIDTH: prdata = 32'(line_width_q);
			tcct_pkg::REG_LINE_COUNT: prdata = 32'(line_count_q);
			tcct_pkg::REG_FILL_ATTR:  prdata = 32'(fill_attr_q);
			default:                  prdata = '0;
		endcase
	end

	tcct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	tcct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (s_tuser),
		.count        (s_tdata[15:0]),
		.new_x        (s_tdata[31:16]),
		.new_y        (s_tdata[47:32]),
		.line_width   (line_width_q),
		.line_count   (line_count_q),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.cursor_moved (cursor_moved),
		.scroll_up    (scroll_up),
		.out_of_range (out_of_range),
		.origin_y     (origin_y)
	);

	// pack the result beat
	assign m_tdata = {5'b0, origin_y, out_of_range, scroll_up, cursor_moved, cursor_y, cursor_x};

endmodule
`default_nettype wire
